@@ sv/iest_pkg.sv @@
package iest_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int KEY_COUNT_DEF  = 256;

    localparam int OP_W       = 3;
    localparam int CODE_W     = 8;
    localparam int POS_W      = 16;
    localparam int BTN_W      = 8;

    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = 56;
    localparam int M_USED_W   = 2 * CODE_W + 2 * POS_W + 3;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_DOWN = 3'd0,
        OP_KEY_UP   = 3'd1,
        OP_CURSOR   = 3'd2,
        OP_BTN_DOWN = 3'd3,
        OP_BTN_UP   = 3'd4,
        OP_POP      = 3'd5,
        OP_CLEAR    = 3'd6,
        OP_INVALID  = 3'd7
    } op_t;

endpackage

@@ sv/input_event_state_tracker_core.sv @@
// Channel  Direction  Handshake         Payload
// s_       in         s_tvalid/tready   s_tuser: operation; s_tdata: key, cursor, buttons
// m_       out        m_tvalid/tready   m_tdata: pop result, key state, cursor, buttons, error
//
// One item per cycle sustained while m_tready is high; each accepted item passes
// through the input register, then the result register, which drives m_tdata.
// The key FIFO is a one-write, one-read memory whose head entry is read ahead
// into a register every cycle, so a pop takes the head from that register.
// Reset (aresetn low, synchronous) clears the key map, pointers, cursor and
// buttons; the FIFO memory itself is not cleared.
// While m_tready is low the result register holds and one more item is taken.
module input_event_state_tracker_core #(
    parameter int FIFO_DEPTH = iest_pkg::FIFO_DEPTH_DEF,
    parameter int KEY_COUNT  = iest_pkg::KEY_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // scancode[7:0], pos_x[23:8], pos_y[39:24], button_bits[47:40]
    input  logic [iest_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [iest_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // popped_key[7:0], popped_valid[8], key_is_down[9], pointer_x[25:10],
    // pointer_y[41:26], buttons[49:42], bad_operation[50], zero[55:51]
    output logic [iest_pkg::M_TDATA_W-1:0]  m_tdata
);
    import iest_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

    logic [CODE_W-1:0]       ring_mem [FIFO_DEPTH];
    logic [CODE_W-1:0]       head_reg;

    logic                    s1_valid_reg, s1_valid_next;
    op_t                     s1_op_reg;
    logic [CODE_W-1:0]       s1_code_reg;
    logic [POS_W-1:0]        s1_x_reg, s1_y_reg;
    logic [BTN_W-1:0]        s1_bits_reg;

    logic [KEY_COUNT-1:0]    map_reg, map_next;
    logic [PTR_W-1:0]        rptr_reg, rptr_next;
    logic [PTR_W-1:0]        wptr_reg, wptr_next;
    logic [POS_W-1:0]        cur_x_reg, cur_x_next;
    logic [POS_W-1:0]        cur_y_reg, cur_y_next;
    logic [BTN_W-1:0]        btn_reg, btn_next;

    logic                    out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;

    logic                    advance;
    logic                    in_map;
    logic [KEY_W-1:0]        key_idx;
    logic                    wr_en;
    logic [CODE_W-1:0]       popped;
    logic                    popped_valid;
    logic                    bad;
    logic                    key_down;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_map  = {1'b0, s1_code_reg} < (CODE_W + 1)'(KEY_COUNT);
    assign key_idx = s1_code_reg[KEY_W-1:0];

    always_comb begin
        map_next     = map_reg;
        rptr_next    = rptr_reg;
        wptr_next    = wptr_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        btn_next     = btn_reg;
        wr_en        = 1'b0;
        popped       = '0;
        popped_valid = 1'b0;
        bad          = 1'b0;
        if (advance) begin
            unique case (s1_op_reg)
                OP_KEY_DOWN: begin
                    if (in_map) begin
                        map_next[key_idx] = 1'b1;
                    end
                    wr_en     = 1'b1;
                    wptr_next = ring_next(wptr_reg);
                    if (wptr_next == rptr_reg) begin
                        rptr_next = ring_next(rptr_reg);
                    end
                end
                OP_KEY_UP: begin
                    if (in_map) begin
                        map_next[key_idx] = 1'b0;
                    end
                end
                OP_CURSOR: begin
                    cur_x_next = s1_x_reg;
                    cur_y_next = s1_y_reg;
                end
                OP_BTN_DOWN: begin
                    btn_next = btn_reg | s1_bits_reg;
                end
                OP_BTN_UP: begin
                    btn_next = btn_reg & ~s1_bits_reg;
                end
                OP_POP: begin
                    if (rptr_reg != wptr_reg) begin
                        popped       = head_reg;
                        popped_valid = 1'b1;
                        rptr_next    = ring_next(rptr_reg);
                    end
                end
                OP_CLEAR: begin
                    map_next   = '0;
                    cur_x_next = '0;
                    cur_y_next = '0;
                    btn_next   = '0;
                end
                OP_INVALID: begin
                    bad = 1'b1;
                end
            endcase
        end
        key_down      = in_map ? map_next[key_idx] : 1'b0;
        out_data_next = {(M_TDATA_W - M_USED_W)'(0), bad, btn_next, cur_y_next, cur_x_next,
                         key_down, popped_valid, popped};
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_tready) begin
            s1_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            map_reg       <= '0;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            btn_reg       <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            map_reg       <= map_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            btn_reg       <= btn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_op_reg   <= op_t'(s_tuser[OP_W-1:0]);
            s1_code_reg <= s_tdata[7:0];
            s1_x_reg    <= s_tdata[23:8];
            s1_y_reg    <= s_tdata[39:24];
            s1_bits_reg <= s_tdata[47:40];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // read ahead the entry at the next read pointer; forward a same-cycle write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wptr_reg] <= s1_code_reg;
        end
        if (wr_en && (wptr_reg == rptr_next)) begin
            head_reg <= s1_code_reg;
        end else begin
            head_reg <= ring_mem[rptr_next];
        end
    end

endmodule

@@ tb/tb_input_event_state_tracker_core.sv @@
`timescale 1ns / 1ps

module tb_input_event_state_tracker_core;
    import iest_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        op_t              op;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [BTN_W-1:0]  bits;
    } tracker_event_t;

    typedef struct packed {
        logic [M_TDATA_W-M_USED_W-1:0] pad;
        logic                          bad;
        logic [BTN_W-1:0]              buttons;
        logic [POS_W-1:0]              cy;
        logic [POS_W-1:0]              cx;
        logic                          down;
        logic                          valid;
        logic [CODE_W-1:0]             key;
    } tracker_result_t;

    class key_state_scoreboard;
        logic [KEY_COUNT_DEF-1:0] key_map;
        logic [CODE_W-1:0]        key_ring [FIFO_DEPTH_DEF];
        int                       rd_ptr;
        int                       wr_ptr;
        logic [POS_W-1:0]         cur_x;
        logic [POS_W-1:0]         cur_y;
        logic [BTN_W-1:0]         held;
        tracker_result_t          expected_q [$];
        int                       mismatches;
        int                       results_seen;

        function new();
            key_map = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            cur_x = '0;
            cur_y = '0;
            held = '0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_event(tracker_event_t ev);
            tracker_result_t r;
            r = '0;
            case (ev.op)
                OP_KEY_DOWN: begin
                    key_map[ev.code] = 1'b1;
                    key_ring[wr_ptr] = ev.code;
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH_DEF;
                    if (wr_ptr == rd_ptr)
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
                end
                OP_KEY_UP: key_map[ev.code] = 1'b0;
                OP_CURSOR: begin
                    cur_x = ev.px;
                    cur_y = ev.py;
                end
                OP_BTN_DOWN: held = held | ev.bits;
                OP_BTN_UP: held = held & ~ev.bits;
                OP_POP: begin
                    if (rd_ptr != wr_ptr) begin
                        r.key = key_ring[rd_ptr];
                        r.valid = 1'b1;
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
                    end
                end
                OP_CLEAR: begin
                    key_map = '0;
                    cur_x = '0;
                    cur_y = '0;
                    held = '0;
                end
                default: r.bad = 1'b1;
            endcase
            r.down = key_map[ev.code];
            r.cx = cur_x;
            r.cy = cur_y;
            r.buttons = held;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string field, longint unsigned want, longint unsigned seen);
            mismatches++;
            $display("result %0d: %s expected 0x%0h, got 0x%0h",
                     results_seen, field, want, seen);
        endtask

        task check_result(logic [M_TDATA_W-1:0] data);
            tracker_result_t got;
            tracker_result_t want;
            got = data;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 0, data);
                return;
            end
            want = expected_q.pop_front();
            if (got.key !== want.key)
                report_mismatch("popped_key", want.key, got.key);
            if (got.valid !== want.valid)
                report_mismatch("popped_valid", want.valid, got.valid);
            if (got.down !== want.down)
                report_mismatch("key_is_down", want.down, got.down);
            if (got.cx !== want.cx)
                report_mismatch("pointer_x", want.cx, got.cx);
            if (got.cy !== want.cy)
                report_mismatch("pointer_y", want.cy, got.cy);
            if (got.buttons !== want.buttons)
                report_mismatch("buttons", want.buttons, got.buttons);
            if (got.bad !== want.bad)
                report_mismatch("bad_operation", want.bad, got.bad);
            if (got.pad !== want.pad)
                report_mismatch("padding", want.pad, got.pad);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int idle_cycles = 0;
    key_state_scoreboard sb;

    input_event_state_tracker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("input_event_state_tracker_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic tracker_event_t make_event(op_t op, logic [CODE_W-1:0] code,
                                                  logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                  logic [BTN_W-1:0] bits);
        tracker_event_t ev;
        ev.op = op;
        ev.code = code;
        ev.px = px;
        ev.py = py;
        ev.bits = bits;
        return ev;
    endfunction

    function automatic tracker_event_t random_event(op_t op);
        logic [CODE_W-1:0] code;
        logic [BTN_W-1:0]  bits;
        code = ($urandom_range(0, 1) == 0) ? CODE_W'($urandom_range(0, 15))
                                           : CODE_W'($urandom_range(0, 255));
        bits = ($urandom_range(0, 1) == 0) ? BTN_W'(1 << $urandom_range(0, 7))
                                           : BTN_W'($urandom_range(0, 255));
        return make_event(op, code, POS_W'($urandom_range(0, 65535)),
                          POS_W'($urandom_range(0, 65535)), bits);
    endfunction

    task automatic send_event(tracker_event_t ev);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev.op;
        s_tdata <= {ev.bits, ev.py, ev.px, ev.code};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ev);
    endtask

    task automatic run_directed();
        send_event(make_event(OP_POP, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_KEY_DOWN, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_KEY_DOWN, 8'd255, 16'hffff, 16'hffff, 8'hff));
        send_event(make_event(OP_KEY_UP, 8'd255, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_KEY_UP, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_CURSOR, 8'd0, 16'h8000, 16'h7fff, 8'h00));
        send_event(make_event(OP_CURSOR, 8'd255, 16'h7fff, 16'h8000, 8'h00));
        send_event(make_event(OP_CURSOR, 8'd1, 16'hffff, 16'h0000, 8'h00));
        send_event(make_event(OP_BTN_DOWN, 8'd0, 16'h0000, 16'h0000, 8'hff));
        send_event(make_event(OP_BTN_UP, 8'd0, 16'h0000, 16'h0000, 8'haa));
        send_event(make_event(OP_BTN_DOWN, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_BTN_UP, 8'd0, 16'h0000, 16'h0000, 8'hff));
        send_event(make_event(OP_BTN_DOWN, 8'd0, 16'h0000, 16'h0000, 8'h81));
        send_event(make_event(OP_INVALID, 8'd0, 16'h1234, 16'h5678, 8'hff));
        send_event(make_event(OP_POP, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_POP, 8'd255, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_POP, 8'd0, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_KEY_DOWN, 8'd7, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_KEY_DOWN, 8'd128, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_CLEAR, 8'd7, 16'hffff, 16'hffff, 8'hff));
        send_event(make_event(OP_INVALID, 8'd128, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_POP, 8'd7, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_POP, 8'd128, 16'h0000, 16'h0000, 8'h00));
        send_event(make_event(OP_POP, 8'd0, 16'h0000, 16'h0000, 8'h00));
    endtask

    task automatic run_random(int count);
        int sent;
        int kind;
        int burst;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            burst = (kind < 5) ? 1 : $urandom_range(1, 80);
            if (burst > count - sent)
                burst = count - sent;
            for (int i = 0; i < burst; i++) begin
                if (kind < 5)
                    send_event(random_event(op_t'($urandom_range(0, 7))));
                else if (kind < 7)
                    send_event(random_event(OP_KEY_DOWN));
                else if (kind < 9)
                    send_event(random_event(OP_POP));
                else
                    send_event(random_event(op_t'($urandom_range(0, 2))));
            end
            sent += burst;
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct = 27;
        receiver_idle_pct = 52;
        run_directed();
        run_random(430);

        sender_idle_pct = 52;
        receiver_idle_pct = 27;
        run_random(450);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random(450);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("input_event_state_tracker_core verification clean");
        else
            $display("input_event_state_tracker_core verification failed");
        $finish;
    end

endmodule
